// ----- sv/weighted_tag_best_match_defines.svh -----
// Assertion macros shared by the weighted_tag_best_match RTL.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef WEIGHTED_TAG_BEST_MATCH_DEFINES_SVH
`define WEIGHTED_TAG_BEST_MATCH_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define WTBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define WTBM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- sv/wtbm_pkg.sv -----
// Shared types and constants for the weighted tag best-match block.
// No dependencies; used by every wtbm_* module and the top level.
`default_nettype none

package wtbm_pkg;

  localparam int unsigned IdxW   = 16;
  localparam int unsigned ValW   = 32;
  localparam int unsigned WgtW   = 24;
  localparam int unsigned RangeW = 40;
  localparam int unsigned TidW   = 6;
  localparam int unsigned SumW   = 63;
  localparam int unsigned DiffW  = 33;
  localparam int unsigned TermW  = 41;
  localparam int unsigned WideW  = 42;
  localparam int unsigned FracW  = 16;

  localparam logic [SumW-1:0]   SumMax       = {SumW{1'b1}};
  localparam logic [RangeW-1:0] DefRangeRst  = 40'd65536000000;
  localparam logic [RangeW-1:0] WrapRangeRst = 40'd411775;
  localparam logic [TidW-1:0]   WrapTidRst   = '0;

  typedef enum logic [1:0] {
    CFG_DEF_RANGE  = 2'd0,
    CFG_WRAP_RANGE = 2'd1,
    CFG_WRAP_TID   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [RangeW-1:0] default_range;
    logic [RangeW-1:0] wrap_range;
    logic [TidW-1:0]   wrap_tag_id;
  } cfg_t;

  // Per-item control that rides along the pipe.
  typedef struct packed {
    logic [IdxW-1:0] asset_index;
    logic            has_tag;
    logic            last_tag;
    logic            last_asset;
  } ctl_t;

  typedef struct packed {
    ctl_t             ctl;
    logic [TidW-1:0]  tag_id;
    logic [ValW-1:0]  tag_value;
    logic [ValW-1:0]  match_value;
    logic [WgtW-1:0]  weight;
  } item_t;

  typedef struct packed {
    logic             valid;
    ctl_t             ctl;
    logic [DiffW-1:0] diff;
    logic [WgtW-1:0]  weight;
  } dist_t;

  typedef struct packed {
    logic             valid;
    ctl_t             ctl;
    logic [TermW-1:0] term;
  } term_t;

endpackage

`default_nettype wire

// ----- sv/wtbm_dist.sv -----
// Input register and wrapped distance stage.
// Depends on wtbm_pkg.
`default_nettype none

module wtbm_dist (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           in_valid_i,
  input  wtbm_pkg::item_t     item_i,
  input  wtbm_pkg::cfg_t      cfg_i,
  output wtbm_pkg::dist_t     dist_o
);

  logic                           a_valid_q;
  wtbm_pkg::item_t                a_item_q;
  logic [wtbm_pkg::RangeW-1:0]    range;
  logic signed [wtbm_pkg::WideW-1:0] a_w, b_w, r_w, ab, shifted;
  logic [wtbm_pkg::WideW-1:0]     d0, d1, dmin;
  wtbm_pkg::dist_t                dist_d, dist_q;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && in_valid_i) begin
      a_item_q <= item_i;
    end
  end

  always_comb begin
    range = (a_item_q.tag_id == cfg_i.wrap_tag_id) ? cfg_i.wrap_range : cfg_i.default_range;
    a_w   = {{(wtbm_pkg::WideW - wtbm_pkg::ValW){a_item_q.match_value[wtbm_pkg::ValW-1]}},
             a_item_q.match_value};
    b_w   = {{(wtbm_pkg::WideW - wtbm_pkg::ValW){a_item_q.tag_value[wtbm_pkg::ValW-1]}},
             a_item_q.tag_value};
    r_w   = {{(wtbm_pkg::WideW - wtbm_pkg::RangeW){1'b0}}, range};
    ab    = a_w - b_w;
    // Shift the match value toward zero by the range; zero counts as positive.
    shifted = a_item_q.match_value[wtbm_pkg::ValW-1] ? (ab + r_w) : (ab - r_w);
    d0    = ab[wtbm_pkg::WideW-1] ? unsigned'(-ab) : unsigned'(ab);
    d1    = shifted[wtbm_pkg::WideW-1] ? unsigned'(-shifted) : unsigned'(shifted);
    dmin  = (d0 < d1) ? d0 : d1;

    dist_d.valid  = a_valid_q;
    dist_d.ctl    = a_item_q.ctl;
    dist_d.diff   = dmin[wtbm_pkg::DiffW-1:0];
    dist_d.weight = a_item_q.weight;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q.valid <= 1'b0;
    end else if (en_i) begin
      dist_q.valid <= dist_d.valid;
      if (dist_d.valid) begin
        dist_q.ctl    <= dist_d.ctl;
        dist_q.diff   <= dist_d.diff;
        dist_q.weight <= dist_d.weight;
      end
    end
  end

  assign dist_o = dist_q;

endmodule

`default_nettype wire

// ----- sv/wtbm_weight.sv -----
// Weighting stage: scales the distance by the Q8.16 weight, keeps Q.16.
// Depends on wtbm_pkg.
`default_nettype none

module wtbm_weight (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wtbm_pkg::dist_t  dist_i,
  output wtbm_pkg::term_t  term_o
);

  localparam int unsigned HiW = wtbm_pkg::DiffW - wtbm_pkg::FracW;

  logic [HiW-1:0]                           diff_hi;
  logic [wtbm_pkg::FracW-1:0]               diff_lo;
  logic [wtbm_pkg::WgtW+HiW-1:0]            p_hi;
  logic [wtbm_pkg::WgtW+wtbm_pkg::FracW-1:0] p_lo;
  logic [wtbm_pkg::TermW-1:0]               term_d;
  wtbm_pkg::term_t                          term_q;

  // floor(w * diff / 2^16) split into integer and fraction parts of diff.
  always_comb begin
    diff_hi = dist_i.diff[wtbm_pkg::DiffW-1:wtbm_pkg::FracW];
    diff_lo = dist_i.diff[wtbm_pkg::FracW-1:0];
    p_hi    = dist_i.weight * diff_hi;
    p_lo    = dist_i.weight * diff_lo;
    term_d  = wtbm_pkg::TermW'(p_hi)
            + wtbm_pkg::TermW'(p_lo[wtbm_pkg::WgtW+wtbm_pkg::FracW-1:wtbm_pkg::FracW]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q.valid <= 1'b0;
    end else if (en_i) begin
      term_q.valid <= dist_i.valid;
      if (dist_i.valid) begin
        term_q.ctl  <= dist_i.ctl;
        term_q.term <= term_d;
      end
    end
  end

  assign term_o = term_q;

endmodule

`default_nettype wire

// ----- sv/wtbm_acc.sv -----
// Accumulate stage: saturating per-asset sum, best tracking, result register.
// Depends on wtbm_pkg and weighted_tag_best_match_defines.svh.
`default_nettype none
`include "weighted_tag_best_match_defines.svh"

module wtbm_acc (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wtbm_pkg::term_t                 term_i,
  output logic                            en_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [wtbm_pkg::IdxW-1:0]       best_index_o,
  output logic [wtbm_pkg::SumW-1:0]       best_score_o
);

  logic [wtbm_pkg::SumW-1:0] run_q, run_d, best_q, best_d, run_add;
  logic [wtbm_pkg::IdxW-1:0] idx_q, idx_d, win_idx;
  logic [wtbm_pkg::SumW-1:0] win_sum;
  logic [wtbm_pkg::SumW:0]   sum_wide;
  logic                      asset_end, emit, hold, consume;
  logic                      out_valid_q;
  logic [wtbm_pkg::IdxW-1:0] out_idx_q;
  logic [wtbm_pkg::SumW-1:0] out_sum_q;

  always_comb begin
    asset_end = !term_i.ctl.has_tag || term_i.ctl.last_tag;
    emit      = asset_end && term_i.ctl.last_asset;
    // Hold the pipe only when a result is due and the slot is still taken.
    hold      = term_i.valid && emit && out_valid_q && out_stall_i;
    consume   = term_i.valid && !hold;

    sum_wide  = {1'b0, run_q} + (wtbm_pkg::SumW + 1)'(term_i.term);
    if (!term_i.ctl.has_tag) begin
      run_add = run_q;
    end else if (sum_wide >= {1'b0, wtbm_pkg::SumMax}) begin
      run_add = wtbm_pkg::SumMax;
    end else begin
      run_add = sum_wide[wtbm_pkg::SumW-1:0];
    end

    // Strictly smaller wins; a tie keeps the earlier asset.
    if (best_q > run_add) begin
      win_sum = run_add;
      win_idx = term_i.ctl.asset_index;
    end else begin
      win_sum = best_q;
      win_idx = idx_q;
    end

    run_d  = run_q;
    best_d = best_q;
    idx_d  = idx_q;
    if (consume) begin
      if (!asset_end) begin
        run_d = run_add;
      end else begin
        run_d = '0;
        if (term_i.ctl.last_asset) begin
          best_d = wtbm_pkg::SumMax;
          idx_d  = '0;
        end else begin
          best_d = win_sum;
          idx_d  = win_idx;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      best_q      <= wtbm_pkg::SumMax;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      best_q <= best_d;
      idx_q  <= idx_d;
      if (consume && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && emit) begin
      out_idx_q <= win_idx;
      out_sum_q <= win_sum;
    end
  end

  assign en_o         = !hold;
  assign out_valid_o  = out_valid_q;
  assign best_index_o = out_idx_q;
  assign best_score_o = out_sum_q;

  `WTBM_ASSERT(a_emit_resets_best, consume && emit |=> best_q == wtbm_pkg::SumMax && idx_q == '0, "best not cleared after emit")
  `WTBM_ASSERT(a_end_clears_sum, consume && asset_end |=> run_q == '0, "running sum not cleared at asset end")
  `WTBM_ASSERT_NEVER(a_no_overwrite, out_valid_q && out_stall_i && consume && emit, "pending result overwritten")
  `WTBM_ASSERT(a_best_monotonic, !(consume && emit) |=> best_q <= $past(best_q), "best sum grew without emit")

endmodule

`default_nettype wire

// ----- sv/weighted_tag_best_match.sv -----
// Weighted tag best match: finds the asset whose weighted distance sum is smallest.
// Depends on wtbm_pkg, wtbm_dist, wtbm_weight and wtbm_acc.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one tag word per cycle: asset
//   index, has_tag, tag id, tag and match values, weight and last_tag / last_asset.
//   An asset ends on last_tag or on a has_tag=0 word; the asset ending with
//   last_asset set produces one result word on out_valid_o / out_stall_i holding
//   the winning index and its saturated sum (index 0 and the maximum if none won).
//   Configuration: write default_range, wrap_range or wrap_tag_id through
//   cfg_valid_i / cfg_index_i / cfg_data_i; cfg_ready_o is always high. Write
//   only while no word is in flight.
// Timing:
//   Four register stages: input register, distance register, weighted term
//   register, then the accumulator and result register. One word per cycle is
//   taken sustained while in_stall_o is low; the combinational running-sum add
//   and compare sets that rate.
// Reset and stall:
//   Reset empties the pipe, zeroes the running sum, sets the best sum to the
//   maximum and restores the configuration defaults. A stalled result holds; the
//   pipe keeps taking words and only halts when a second result is ready to leave
//   while the first is still stalled.
`default_nettype none

module weighted_tag_best_match (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [wtbm_pkg::IdxW-1:0]     asset_index_i,
  input  wire logic                          has_tag_i,
  input  wire logic [wtbm_pkg::TidW-1:0]     tag_id_i,
  input  wire logic signed [wtbm_pkg::ValW-1:0] tag_value_i,
  input  wire logic signed [wtbm_pkg::ValW-1:0] match_value_i,
  input  wire logic [wtbm_pkg::WgtW-1:0]     weight_i,
  input  wire logic                          last_tag_i,
  input  wire logic                          last_asset_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [wtbm_pkg::IdxW-1:0]          best_index_o,
  output logic [wtbm_pkg::SumW-1:0]          best_score_o,
  // configuration channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [wtbm_pkg::RangeW-1:0]   cfg_data_i
);

  wtbm_pkg::cfg_t  cfg_q;
  wtbm_pkg::item_t item;
  wtbm_pkg::dist_t dist_pipe;
  wtbm_pkg::term_t term;
  logic            en;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; unknown indexes drop the write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.default_range <= wtbm_pkg::DefRangeRst;
      cfg_q.wrap_range    <= wtbm_pkg::WrapRangeRst;
      cfg_q.wrap_tag_id   <= wtbm_pkg::WrapTidRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        wtbm_pkg::CFG_DEF_RANGE:  cfg_q.default_range <= cfg_data_i;
        wtbm_pkg::CFG_WRAP_RANGE: cfg_q.wrap_range    <= cfg_data_i;
        wtbm_pkg::CFG_WRAP_TID:   cfg_q.wrap_tag_id   <= cfg_data_i[wtbm_pkg::TidW-1:0];
        default: ;
      endcase
    end
  end

  // Pack the input word.
  always_comb begin
    item.ctl.asset_index = asset_index_i;
    item.ctl.has_tag     = has_tag_i;
    item.ctl.last_tag    = last_tag_i;
    item.ctl.last_asset  = last_asset_i;
    item.tag_id          = tag_id_i;
    item.tag_value       = tag_value_i;
    item.match_value     = match_value_i;
    item.weight          = weight_i;
  end

  // The whole pipe advances together; it stops only behind a blocked result.
  assign in_stall_o = !en;

  wtbm_dist u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .item_i     (item),
    .cfg_i      (cfg_q),
    .dist_o     (dist_pipe)
  );

  wtbm_weight u_weight (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .dist_i (dist_pipe),
    .term_o (term)
  );

  wtbm_acc u_acc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .term_i       (term),
    .en_o         (en),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .best_index_o (best_index_o),
    .best_score_o (best_score_o)
  );

endmodule

`default_nettype wire
